@@ src/flr_pkg.sv @@
// Shared types and constants for the fixed-point line rasterizer.
// No dependencies; imported by flr_ctrl, flr_dp and the top level.
`timescale 1ns / 1ps

package flr_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_DIM_DEF   = 4096;

  // Bounds-check register reset values
  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;

  // Request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_DIV
  } state_t;

  typedef struct packed {
    logic capture;  // latch endpoints of a start beat
    logic setup;    // pick major axis, load line state, emit far endpoint
    logic div_run;  // one slope-division iteration
    logic pixel;    // emit one stepped pixel and advance
  } cmd_t;

  typedef struct packed {
    logic out_valid;
    logic line_active;
    logic div_last;
  } status_t;

endpackage

@@ src/fixed_point_line_rasterizer.sv @@
// Step beat: accepted one per cycle while idle and the output is not
// stalled; pixel valid the cycle after acceptance if a line is active.
// Start beat: capture, setup (far endpoint emitted, held off by a stalled
// output), then the bit-serial slope divider; next beat taken once it is done.
// Reset (rst_n low, synchronous): no active line, output empty,
// image_width = 640, image_height = 480.
`timescale 1ns / 1ps

module fixed_point_line_rasterizer import flr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_DIM   = MAX_DIM_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_req_type,
  input  logic [$clog2(MAX_DIM)+FRAC_BITS-1:0] in_x_start,
  input  logic [$clog2(MAX_DIM)+FRAC_BITS-1:0] in_y_start,
  input  logic [$clog2(MAX_DIM)+FRAC_BITS-1:0] in_x_end,
  input  logic [$clog2(MAX_DIM)+FRAC_BITS-1:0] in_y_end,
  input  logic [7:0]                           in_pixel_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [$clog2(MAX_DIM):0]             out_pixel_x,
  output logic [$clog2(MAX_DIM):0]             out_pixel_y,
  output logic                                 out_in_image,
  output logic [7:0]                           out_value_out,
  output logic                                 out_last_pixel,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [CFG_IDX_W-1:0]                 cfg_index,
  input  logic [$clog2(MAX_DIM):0]             cfg_data
);

  localparam int CW = $clog2(MAX_DIM) + 1;

  logic [CW-1:0] image_width_r, image_height_r;
  cmd_t          cmd;
  status_t       status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= CW'(WIDTH_RST);
      image_height_r <= CW'(HEIGHT_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  flr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .out_ready   (out_ready),
    .status      (status),
    .in_ready    (in_ready),
    .cmd         (cmd)
  );

  flr_dp #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_DIM   (MAX_DIM)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_x_start     (in_x_start),
    .in_y_start     (in_y_start),
    .in_x_end       (in_x_end),
    .in_y_end       (in_y_end),
    .in_pixel_value (in_pixel_value),
    .image_width    (image_width_r),
    .image_height   (image_height_r),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_in_image   (out_in_image),
    .out_value_out  (out_value_out),
    .out_last_pixel (out_last_pixel)
  );

endmodule

@@ src/flr_ctrl.sv @@
// Sequencing state machine for the line rasterizer.
// Depends on flr_pkg; drives flr_dp through cmd_t and reads status_t.
`timescale 1ns / 1ps

module flr_ctrl import flr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_req_type,
  input  logic    out_ready,
  input  status_t status,
  output logic    in_ready,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_stall;
  logic   accept;

  // output slot is free when empty or being drained this cycle
  assign out_stall = status.out_valid && !out_ready;
  assign in_ready  = (state_r == S_IDLE) && !out_stall;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_req_type == REQ_START)) state_nxt = S_SETUP;
      end
      S_SETUP: begin
        if (!out_stall) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (status.div_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.capture = accept && (in_req_type == REQ_START);
    cmd.pixel   = accept && (in_req_type == REQ_STEP) && status.line_active;
    case (state_r)
      S_SETUP: cmd.setup   = !out_stall;
      S_DIV:   cmd.div_run = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ src/flr_dp.sv @@
// Datapath of the line rasterizer: endpoint capture, axis selection,
// bit-serial slope divider, DDA stepper and output register. Uses flr_pkg.
`timescale 1ns / 1ps

module flr_dp import flr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_DIM   = MAX_DIM_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cmd_t                                 cmd,
  output status_t                              status,
  input  logic [$clog2(MAX_DIM)+FRAC_BITS-1:0] in_x_start,
  input  logic [$clog2(MAX_DIM)+FRAC_BITS-1:0] in_y_start,
  input  logic [$clog2(MAX_DIM)+FRAC_BITS-1:0] in_x_end,
  input  logic [$clog2(MAX_DIM)+FRAC_BITS-1:0] in_y_end,
  input  logic [7:0]                           in_pixel_value,
  input  logic [$clog2(MAX_DIM):0]             image_width,
  input  logic [$clog2(MAX_DIM):0]             image_height,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [$clog2(MAX_DIM):0]             out_pixel_x,
  output logic [$clog2(MAX_DIM):0]             out_pixel_y,
  output logic                                 out_in_image,
  output logic [7:0]                           out_value_out,
  output logic                                 out_last_pixel
);

  localparam int IN_W   = $clog2(MAX_DIM) + FRAC_BITS;
  localparam int CW     = $clog2(MAX_DIM) + 1;
  localparam int HW     = IN_W + 1;          // endpoint plus half pixel
  localparam int CNT_W  = IN_W - FRAC_BITS;
  localparam int QW     = FRAC_BITS + 1;     // |step| <= 1.0
  localparam int SW     = FRAC_BITS + 2;
  localparam int ACC_W  = IN_W + 2;
  localparam int DCW    = $clog2(FRAC_BITS + 1);
  localparam logic [HW-1:0]  HALF     = HW'(1) << (FRAC_BITS - 1);
  localparam logic [DCW-1:0] DIV_LAST = DCW'(FRAC_BITS);

  // captured endpoints, already offset by half a pixel
  logic [HW-1:0]    xh1_r, yh1_r, xh2_r, yh2_r;
  logic [7:0]       held_value_r;

  // line state
  logic [CW-1:0]    major_coord_r;
  logic [ACC_W-1:0] minor_accum_r;
  logic [SW-1:0]    minor_step_r;
  logic [CNT_W-1:0] remaining_count_r;
  logic             x_is_major_r;
  logic             line_active_r;

  // divider
  logic [IN_W-1:0]  div_r, rem_r, rem_nxt;
  logic [QW-1:0]    q_r, q_nxt;
  logic             neg_r;
  logic [DCW-1:0]   dcnt_r;

  // output register
  logic             out_valid_r;
  logic [CW-1:0]    out_x_r, out_y_r;
  logic             out_in_r, out_last_r;
  logic [7:0]       out_val_r;

  // ---------------- axis selection ----------------
  logic            dx_neg, dy_neg, x_major, maj_neg, min_neg;
  logic [IN_W-1:0] ax, ay, amaj, amin;
  logic [HW-1:0]   sx, sy, fx, fy, maj_start, min_start;

  always_comb begin
    dx_neg  = xh2_r < xh1_r;
    dy_neg  = yh2_r < yh1_r;
    ax      = dx_neg ? IN_W'(xh1_r - xh2_r) : IN_W'(xh2_r - xh1_r);
    ay      = dy_neg ? IN_W'(yh1_r - yh2_r) : IN_W'(yh2_r - yh1_r);
    x_major = ax > ay;  // ties go to y
    maj_neg = x_major ? dx_neg : dy_neg;
    min_neg = x_major ? dy_neg : dx_neg;
    amaj    = x_major ? ax : ay;
    amin    = x_major ? ay : ax;
    // order endpoints so the major coordinate rises
    sx = maj_neg ? xh2_r : xh1_r;
    sy = maj_neg ? yh2_r : yh1_r;
    fx = maj_neg ? xh1_r : xh2_r;
    fy = maj_neg ? yh1_r : yh2_r;
    maj_start = x_major ? sx : sy;
    min_start = x_major ? sy : sx;
  end

  // ---------------- restoring divider, one quotient bit a cycle ----------------
  logic [IN_W:0] trial, trial_diff;
  logic          ge;
  logic [SW-1:0] q_ext;

  always_comb begin
    // first iteration yields the integer bit without a shift
    trial      = (dcnt_r == '0) ? {1'b0, rem_r} : {rem_r, 1'b0};
    trial_diff = trial - {1'b0, div_r};
    ge         = trial >= {1'b0, div_r};
    rem_nxt    = ge ? trial_diff[IN_W-1:0] : trial[IN_W-1:0];
    q_nxt      = {q_r[QW-2:0], ge};
    q_ext      = {1'b0, q_nxt};
  end

  // ---------------- DDA pixel ----------------
  logic          acc_neg, last;
  logic [CW-1:0] mn, px, py;

  always_comb begin
    acc_neg = minor_accum_r[ACC_W-1];
    mn      = acc_neg ? '0 : minor_accum_r[ACC_W-2:FRAC_BITS];
    px      = x_is_major_r ? major_coord_r : mn;
    py      = x_is_major_r ? mn : major_coord_r;
    last    = remaining_count_r == '0;
  end

  // ---------------- output selection ----------------
  logic [CW-1:0] ld_x, ld_y;
  logic          ld_neg;

  always_comb begin
    ld_x   = cmd.setup ? fx[HW-1:FRAC_BITS] : px;
    ld_y   = cmd.setup ? fy[HW-1:FRAC_BITS] : py;
    ld_neg = cmd.setup ? 1'b0 : acc_neg;
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r <= 1'b0;
      out_valid_r   <= 1'b0;
      dcnt_r        <= '0;
    end else begin
      if (cmd.setup || cmd.pixel) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.capture) begin
        line_active_r <= 1'b0;
      end else if (cmd.setup) begin
        line_active_r <= 1'b1;
      end else if (cmd.pixel && last) begin
        line_active_r <= 1'b0;
      end
      if (cmd.setup) begin
        dcnt_r <= '0;
      end else if (cmd.div_run) begin
        dcnt_r <= dcnt_r + DCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      xh1_r        <= {1'b0, in_x_start} + HALF;
      yh1_r        <= {1'b0, in_y_start} + HALF;
      xh2_r        <= {1'b0, in_x_end} + HALF;
      yh2_r        <= {1'b0, in_y_end} + HALF;
      held_value_r <= in_pixel_value;
    end
    if (cmd.setup) begin
      x_is_major_r      <= x_major;
      major_coord_r     <= maj_start[HW-1:FRAC_BITS];
      minor_accum_r     <= {1'b0, min_start};
      remaining_count_r <= amaj[IN_W-1:FRAC_BITS];
      div_r             <= amaj | IN_W'(1);
      rem_r             <= amin;
      neg_r             <= maj_neg ^ min_neg;
      q_r               <= '0;
    end else if (cmd.div_run) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      if (dcnt_r == DIV_LAST) begin
        minor_step_r <= neg_r ? SW'(-q_ext) : q_ext;
      end
    end else if (cmd.pixel) begin
      major_coord_r <= major_coord_r + CW'(1);
      minor_accum_r <= minor_accum_r
                       + {{(ACC_W-SW){minor_step_r[SW-1]}}, minor_step_r};
      if (!last) begin
        remaining_count_r <= remaining_count_r - CNT_W'(1);
      end
    end
    if (cmd.setup || cmd.pixel) begin
      out_x_r    <= ld_x;
      out_y_r    <= ld_y;
      out_in_r   <= !ld_neg && (ld_x < image_width) && (ld_y < image_height);
      out_val_r  <= held_value_r;
      out_last_r <= cmd.pixel && last;
    end
  end

  always_comb begin
    status.out_valid   = out_valid_r;
    status.line_active = line_active_r;
    status.div_last    = cmd.div_run && (dcnt_r == DIV_LAST);
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_x    = out_x_r;
  assign out_pixel_y    = out_y_r;
  assign out_in_image   = out_in_r;
  assign out_value_out  = out_val_r;
  assign out_last_pixel = out_last_r;

endmodule
